// ===== rtl/core/modrm_sib_operand_decode_defines.svh =====
// ---------------------------------------------------------------------------
// modrm_sib_operand_decode_defines.svh
// Assertion macros shared by the operand decoder RTL.
// ---------------------------------------------------------------------------
`ifndef MODRM_SIB_OPERAND_DECODE_DEFINES_SVH
`define MODRM_SIB_OPERAND_DECODE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MSOD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MSOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/msod_pkg.sv =====
// ---------------------------------------------------------------------------
// msod_pkg
// Types, codes and helpers for the ModRM/SIB operand decoder.
// ---------------------------------------------------------------------------
package msod_pkg;

    localparam int TAIL_W = 40;
    localparam int DISP_W = 32;

    // ModRM fields
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP32  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;
    localparam logic [2:0] RM_SIB      = 3'd4;
    localparam logic [2:0] RM_RIPDISP  = 3'd5;
    localparam logic [2:0] SIB_NO_BASE = 3'd5;
    localparam logic [2:0] SIB_NO_IDX  = 3'd4;

    // operand size codes
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;
    localparam logic [2:0] OVR_MIN = 3'd1;
    localparam logic [2:0] OVR_MAX = 3'd4;

    typedef enum logic [1:0] {
        KIND_REG  = 2'd0,
        KIND_DISP = 2'd1,
        KIND_BASE = 2'd2,
        KIND_SIB  = 2'd3
    } rm_kind_t;

    typedef enum logic [1:0] {
        DLEN_NONE = 2'd0,
        DLEN_8    = 2'd1,
        DLEN_32   = 2'd2
    } disp_len_t;

    // stage 1: prefixes resolved, ModRM split
    typedef struct packed {
        logic [1:0]        pfx_cnt;
        logic [1:0]        size;
        logic [3:0]        reg_op;
        logic              rex_x;
        logic              rex_b;
        logic [1:0]        mod;
        logic [2:0]        rm;
        logic [TAIL_W-1:0] tail;
    } s1_t;

    // stage 2: operand form decoded
    typedef struct packed {
        logic [1:0]        pfx_cnt;
        logic [1:0]        size;
        logic [3:0]        reg_op;
        rm_kind_t          kind;
        logic [3:0]        rm_reg;
        logic              bval;
        logic [3:0]        breg;
        logic              ival;
        logic [3:0]        ireg;
        logic [1:0]        scale;
        logic              sib_used;
        disp_len_t         dlen;
        logic [TAIL_W-1:0] tail;
    } s2_t;

    // stage 3: finished result
    typedef struct packed {
        rm_kind_t          kind;
        logic [1:0]        size;
        logic [3:0]        reg_op;
        logic [3:0]        rm_reg;
        logic              bval;
        logic [3:0]        breg;
        logic              ival;
        logic [3:0]        ireg;
        logic [1:0]        scale;
        logic [DISP_W-1:0] disp;
        logic [3:0]        bytes;
    } s3_t;

    function automatic logic [3:0] disp_bytes(input disp_len_t dlen);
        logic [3:0] n;
        unique case (dlen)
            DLEN_8:  n = 4'd1;
            DLEN_32: n = 4'd4;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/modrm_sib_operand_decode.sv =====
// ---------------------------------------------------------------------------
// modrm_sib_operand_decode
// x86-64 ModRM/SIB operand decoder, three-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries the prefix flags, the
//   size override, the ModRM byte and the five bytes that follow it.
//   Response channel (rsp_valid/rsp_ready) returns one decoded operand per
//   request: r/m form, operand size, reg operand, base/index/scale,
//   sign-extended displacement and the byte count.
//   Path: a request moves through registered stages 1, 2 and 3; rsp_valid
//   rises when it reaches stage 3, and it is taken while rsp_ready is high.
//   Throughput: one request per cycle while not stalled; a stage holds
//   one request, advancing when the stage downstream is empty or moving.
//   Stalls: when rsp_ready is low the output stage holds its result and the
//   upper stages keep filling bubbles; req_ready drops only once all three
//   stages hold a request. Nothing is dropped or repeated.
//   Reset: rst_n clears all stage valid bits; the data registers are not
//   reset, and the block accepts a request as soon as reset is released.
// Stage work:
//   1 - REX masking, operand size, reg field, prefix count.
//   2 - r/m form, base/index/scale, displacement length.
//   3 - displacement extraction and sign extension, byte count.
// ---------------------------------------------------------------------------
`include "modrm_sib_operand_decode_defines.svh"

module modrm_sib_operand_decode
    import msod_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                has_opsize_prefix,
    input  logic                has_rex,
    input  logic [3:0]          rex_low_bits,
    input  logic [2:0]          size_override,
    input  logic [7:0]          modrm_byte,
    input  logic [TAIL_W-1:0]   tail_bytes,
    // response channel
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          rm_kind,
    output logic [1:0]          operand_size,
    output logic [3:0]          reg_operand,
    output logic [3:0]          rm_register,
    output logic                base_valid,
    output logic [3:0]          base_regnum,
    output logic                index_valid,
    output logic [3:0]          index_regnum,
    output logic [1:0]          scale_log2,
    output logic signed [DISP_W-1:0] displacement,
    output logic [3:0]          bytes_used
);

    // -----------------------------------------------------------------------
    // stage valid bits and flow control
    // -----------------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic s1_free, s2_free, s3_free;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;

    // a stage can load when it is empty or its content moves on this cycle
    assign s3_free   = !v3_reg || rsp_ready;
    assign s2_free   = !v2_reg || s3_free;
    assign s1_free   = !v1_reg || s2_free;
    assign req_ready = s1_free;

    assign v1_next = s1_free ? req_valid : v1_reg;
    assign v2_next = s2_free ? v1_reg    : v2_reg;
    assign v3_next = s3_free ? v2_reg    : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // -----------------------------------------------------------------------
    // stage 1: prefixes and ModRM split
    // -----------------------------------------------------------------------
    always_comb
    begin
        logic [3:0] rex;
        rex = has_rex ? rex_low_bits : 4'd0;

        // default 32, 0x66 gives 16, REX.W wins, override 1..4 replaces all
        if (size_override >= OVR_MIN && size_override <= OVR_MAX)
            s1_next.size = 2'(size_override - OVR_MIN);
        else if (rex[3])
            s1_next.size = SIZE_64;
        else if (has_opsize_prefix)
            s1_next.size = SIZE_16;
        else
            s1_next.size = SIZE_32;

        s1_next.pfx_cnt = {1'b0, has_opsize_prefix} + {1'b0, has_rex};
        s1_next.reg_op  = {rex[2], modrm_byte[5:3]};
        s1_next.rex_x   = rex[1];
        s1_next.rex_b   = rex[0];
        s1_next.mod     = modrm_byte[7:6];
        s1_next.rm      = modrm_byte[2:0];
        s1_next.tail    = tail_bytes;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
            s1_reg <= s1_next;
    end

    // -----------------------------------------------------------------------
    // stage 2: r/m form
    // -----------------------------------------------------------------------
    always_comb
    begin
        logic [1:0] sib_s;
        logic [2:0] sib_i;
        logic [2:0] sib_b;
        sib_s = s1_reg.tail[7:6];
        sib_i = s1_reg.tail[5:3];
        sib_b = s1_reg.tail[2:0];

        s2_next.pfx_cnt  = s1_reg.pfx_cnt;
        s2_next.size     = s1_reg.size;
        s2_next.reg_op   = s1_reg.reg_op;
        s2_next.tail     = s1_reg.tail;
        s2_next.kind     = KIND_REG;
        s2_next.rm_reg   = 4'd0;
        s2_next.bval     = 1'b0;
        s2_next.breg     = 4'd0;
        s2_next.ival     = 1'b0;
        s2_next.ireg     = 4'd0;
        s2_next.scale    = 2'd0;
        s2_next.sib_used = 1'b0;

        unique case (s1_reg.mod)
            MOD_DISP8:  s2_next.dlen = DLEN_8;
            MOD_DISP32: s2_next.dlen = DLEN_32;
            default:    s2_next.dlen = DLEN_NONE;
        endcase

        if (s1_reg.mod == MOD_REG)
        begin
            s2_next.rm_reg = {s1_reg.rex_b, s1_reg.rm};
        end
        else if (s1_reg.rm == RM_SIB)
        begin
            s2_next.kind     = KIND_SIB;
            s2_next.sib_used = 1'b1;
            // no base with mod 0: disp32 follows the SIB instead
            if (s1_reg.mod == MOD_NO_DISP && sib_b == SIB_NO_BASE)
                s2_next.dlen = DLEN_32;
            else
            begin
                s2_next.bval = 1'b1;
                s2_next.breg = {s1_reg.rex_b, sib_b};
            end
            // index 4 means none unless REX.X lifts it to r12
            if (sib_i != SIB_NO_IDX || s1_reg.rex_x)
            begin
                s2_next.ival  = 1'b1;
                s2_next.ireg  = {s1_reg.rex_x, sib_i};
                s2_next.scale = sib_s;
            end
        end
        else if (s1_reg.mod == MOD_NO_DISP && s1_reg.rm == RM_RIPDISP)
        begin
            s2_next.kind = KIND_DISP;
            s2_next.dlen = DLEN_32;
        end
        else
        begin
            s2_next.kind = KIND_BASE;
            s2_next.bval = 1'b1;
            s2_next.breg = {s1_reg.rex_b, s1_reg.rm};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
            s2_reg <= s2_next;
    end

    // -----------------------------------------------------------------------
    // stage 3: displacement and byte count
    // -----------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]        d8;
        logic [DISP_W-1:0] d32;
        // displacement starts right after the SIB byte when there is one
        d8  = s2_reg.sib_used ? s2_reg.tail[15:8] : s2_reg.tail[7:0];
        d32 = s2_reg.sib_used ? s2_reg.tail[39:8] : s2_reg.tail[31:0];

        s3_next.kind   = s2_reg.kind;
        s3_next.size   = s2_reg.size;
        s3_next.reg_op = s2_reg.reg_op;
        s3_next.rm_reg = s2_reg.rm_reg;
        s3_next.bval   = s2_reg.bval;
        s3_next.breg   = s2_reg.breg;
        s3_next.ival   = s2_reg.ival;
        s3_next.ireg   = s2_reg.ireg;
        s3_next.scale  = s2_reg.scale;

        case (s2_reg.dlen)
            DLEN_8:  s3_next.disp = {{(DISP_W-8){d8[7]}}, d8};
            DLEN_32: s3_next.disp = d32;
            default: s3_next.disp = '0;
        endcase

        s3_next.bytes = {2'd0, s2_reg.pfx_cnt} + 4'd1 + {3'd0, s2_reg.sib_used}
                      + disp_bytes(s2_reg.dlen);
    end

    always_ff @(posedge clk)
    begin
        if (s3_free)
            s3_reg <= s3_next;
    end

    // -----------------------------------------------------------------------
    // outputs
    // -----------------------------------------------------------------------
    assign rsp_valid    = v3_reg;
    assign rm_kind      = s3_reg.kind;
    assign operand_size = s3_reg.size;
    assign reg_operand  = s3_reg.reg_op;
    assign rm_register  = s3_reg.rm_reg;
    assign base_valid   = s3_reg.bval;
    assign base_regnum  = s3_reg.breg;
    assign index_valid  = s3_reg.ival;
    assign index_regnum = s3_reg.ireg;
    assign scale_log2   = s3_reg.scale;
    assign displacement = s3_reg.disp;
    assign bytes_used   = s3_reg.bytes;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    `MSOD_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, v1_reg,
        "accepted request did not reach stage 1")
    `MSOD_ASSERT_NEXT(a_stall_keeps_out, rsp_valid && !rsp_ready, rsp_valid && $stable(s3_reg),
        "output stage changed while stalled")
    `MSOD_ASSERT_SAME(a_reg_form_no_mem, rsp_valid && rm_kind == KIND_REG,
        !base_valid && !index_valid && displacement == '0,
        "register operand carries memory fields")
    `MSOD_ASSERT_SAME(a_index_needs_sib, rsp_valid && index_valid, rm_kind == KIND_SIB,
        "index register outside SIB form")
    `MSOD_ASSERT_SAME(a_disp_only_len, rsp_valid && rm_kind == KIND_DISP,
        !base_valid && bytes_used >= 4'd5,
        "displacement-only form with base or short length")

endmodule
